[src/mfde_pkg.sv]
// Package for the monochrome framebuffer draw engine.
// Holds geometry constants, command codes and the sequencer state type; no dependencies.
`default_nettype none
package mfde_pkg;

  localparam int COLUMNS      = 128;
  localparam int ROWS         = 64;
  localparam int BUFFER_BYTES = 1024;
  localparam int ADDR_W       = 10;

  typedef enum logic [2:0] {
    MODE_SET   = 3'd0,
    MODE_CLR   = 3'd1,
    MODE_INV   = 3'd2,
    MODE_LINE  = 3'd3,
    MODE_RECT  = 3'd4,
    MODE_WIPE  = 3'd5,
    MODE_READ  = 3'd6,
    MODE_BAD   = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIPE,
    ST_RD,
    ST_WAIT,
    ST_WR,
    ST_NEXT,
    ST_RDB,
    ST_RDBW,
    ST_OUT
  } state_t;

  // Pixel operation applied in the read-modify-write step.
  typedef enum logic [1:0] {
    POP_SET = 2'd0,
    POP_CLR = 2'd1,
    POP_INV = 2'd2
  } pop_t;

endpackage
`default_nettype wire

[src/mfde_fb_ram.sv]
// Frame buffer memory: one write port, one registered read port.
// Depends on mfde_pkg for the depth and address width.
`default_nettype none
module mfde_fb_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [mfde_pkg::ADDR_W-1:0] waddr,
  input  wire logic [7:0]                 wdata,
  input  wire logic [mfde_pkg::ADDR_W-1:0] raddr,
  output logic      [7:0]                 rdata
);

  logic [7:0] mem [mfde_pkg::BUFFER_BYTES];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/mono_framebuffer_draw_engine.sv]
// Top level of the monochrome framebuffer draw engine.
// Depends on mfde_pkg and mfde_fb_ram.
`default_nettype none
// Each command item runs through a small sequencer around one frame buffer
// memory port. A pixel touch is a read-modify-write of one byte through the
// states ST_RD, ST_WAIT and ST_WR, and ST_NEXT then steps to the next point;
// a line has up to 128 pixels. A read passes through ST_RDB and ST_RDBW, a
// rejected command or an empty rectangle goes straight to the result, and a
// clear command sweeps all 1024 bytes at one byte a cycle. While out_stall
// is high the result is held. After reset the block runs the same sweep,
// gives no result item for it and accepts no item meanwhile. One result item
// follows each command; in_stall is high while a command is in progress or
// its result waits to be taken.
module mono_framebuffer_draw_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_x_start,
  input  wire logic [7:0] in_y_start,
  input  wire logic [6:0] in_x_end,
  input  wire logic [5:0] in_y_end,
  input  wire logic [7:0] in_rect_width,
  input  wire logic [7:0] in_rect_height,
  input  wire logic [9:0] in_byte_address,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_status,
  output logic      [7:0] out_read_data
);

  localparam int AW = mfde_pkg::ADDR_W;

  mfde_pkg::state_t st_r, st_nxt;

  // Working registers.
  logic [6:0]       x_r, xe_r, x0_r;
  logic [5:0]       y_r, ye_r, y0_r;
  logic [7:0]       w_r, h_r;
  logic signed [9:0] d_r;
  logic [7:0]       dx_r, dy_r;
  logic             sx_r, sy_r, xmaj_r, is_line_r;
  mfde_pkg::pop_t   pop_r;
  logic [AW-1:0]    wcnt_r;
  logic [AW-1:0]    raddr_r;
  logic             boot_r;
  logic             status_r;
  logic [7:0]       data_r;
  logic             stat_nxt;
  logic             go_draw, go_wipe, go_read, go_out;

  logic             we;
  logic [AW-1:0]    pix_addr;
  logic [7:0]       rdata, wdata, bitm;

  assign in_stall  = (st_r != mfde_pkg::ST_IDLE);
  assign out_valid = (st_r == mfde_pkg::ST_OUT);
  assign out_status    = status_r;
  assign out_read_data = data_r;

  wire accept = in_valid && (st_r == mfde_pkg::ST_IDLE);
  wire is_line_cmd = (in_mode == 3'(mfde_pkg::MODE_LINE));

  // Range checks for the incoming command.
  logic [8:0] xr_sum, yr_sum;
  logic [7:0] adx, ady;
  assign xr_sum = {1'b0, in_x_start} + {1'b0, in_rect_width};
  assign yr_sum = {1'b0, in_y_start} + {1'b0, in_rect_height};
  assign adx = (in_x_end >= in_x_start[6:0]) ? {1'b0, in_x_end - in_x_start[6:0]}
                                             : {1'b0, in_x_start[6:0] - in_x_end};
  assign ady = (in_y_end >= in_y_start[5:0]) ? {2'b0, in_y_end - in_y_start[5:0]}
                                             : {2'b0, in_y_start[5:0] - in_y_end};
  wire pix_ok = (in_x_start < 8'(mfde_pkg::COLUMNS)) && (in_y_start < 8'(mfde_pkg::ROWS));
  wire rect_ok = pix_ok && (xr_sum <= 9'(mfde_pkg::COLUMNS)) &&
                 (yr_sum <= 9'(mfde_pkg::ROWS));
  wire rect_empty = (in_rect_width == 8'd0) || (in_rect_height == 8'd0);

  // Command decode into status and which engine path runs.
  always_comb begin
    stat_nxt = 1'b0;
    go_draw  = 1'b0;
    go_wipe  = 1'b0;
    go_read  = 1'b0;
    go_out   = 1'b0;
    unique case (mfde_pkg::mode_t'(in_mode))
      mfde_pkg::MODE_SET, mfde_pkg::MODE_CLR, mfde_pkg::MODE_INV,
      mfde_pkg::MODE_LINE: begin
        stat_nxt = !pix_ok;
        go_draw  = pix_ok;
        go_out   = !pix_ok;
      end
      mfde_pkg::MODE_RECT: begin
        stat_nxt = !rect_ok;
        go_draw  = rect_ok && !rect_empty;
        go_out   = !(rect_ok && !rect_empty);
      end
      mfde_pkg::MODE_WIPE: go_wipe = 1'b1;
      mfde_pkg::MODE_READ: begin
        stat_nxt = ({1'b0, in_byte_address} >= 11'(mfde_pkg::BUFFER_BYTES));
        go_read  = !stat_nxt;
        go_out   = stat_nxt;
      end
      default: begin
        stat_nxt = 1'b1;
        go_out   = 1'b1;
      end
    endcase
  end

  // Completion check for the current point of a line or a rectangle.
  logic last_pt;
  always_comb begin
    if (is_line_r) begin
      last_pt = xmaj_r ? (x_r == xe_r) : (y_r == ye_r);
    end else begin
      last_pt = (x_r == x0_r + w_r[6:0] - 7'd1) && (y_r == y0_r + h_r[5:0] - 6'd1);
    end
  end

  // Next state; the sweep after reset returns to idle without a result item.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mfde_pkg::ST_IDLE: begin
        if (accept) begin
          if (go_wipe)      st_nxt = mfde_pkg::ST_WIPE;
          else if (go_draw) st_nxt = mfde_pkg::ST_RD;
          else if (go_read) st_nxt = mfde_pkg::ST_RDB;
          else if (go_out)  st_nxt = mfde_pkg::ST_OUT;
        end
      end
      mfde_pkg::ST_WIPE: begin
        if (wcnt_r == AW'(mfde_pkg::BUFFER_BYTES - 1)) begin
          st_nxt = boot_r ? mfde_pkg::ST_IDLE : mfde_pkg::ST_OUT;
        end
      end
      mfde_pkg::ST_RD:   st_nxt = mfde_pkg::ST_WAIT;
      mfde_pkg::ST_WAIT: st_nxt = mfde_pkg::ST_WR;
      mfde_pkg::ST_WR:   st_nxt = last_pt ? mfde_pkg::ST_OUT : mfde_pkg::ST_NEXT;
      mfde_pkg::ST_NEXT: st_nxt = mfde_pkg::ST_RD;
      mfde_pkg::ST_RDB:  st_nxt = mfde_pkg::ST_RDBW;
      mfde_pkg::ST_RDBW: st_nxt = mfde_pkg::ST_OUT;
      mfde_pkg::ST_OUT:  if (!out_stall) st_nxt = mfde_pkg::ST_IDLE;
      default:           st_nxt = mfde_pkg::ST_IDLE;
    endcase
  end

  // Memory port and modify step.
  assign pix_addr = {y_r[5:3], x_r};
  assign bitm     = 8'd1 << y_r[2:0];
  always_comb begin
    unique case (pop_r)
      mfde_pkg::POP_SET: wdata = rdata | bitm;
      mfde_pkg::POP_CLR: wdata = rdata & ~bitm;
      default:           wdata = rdata ^ bitm;
    endcase
    if (st_r == mfde_pkg::ST_WIPE) wdata = 8'h00;
  end
  assign we = (st_r == mfde_pkg::ST_WR) || (st_r == mfde_pkg::ST_WIPE);

  mfde_fb_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr ((st_r == mfde_pkg::ST_WIPE) ? wcnt_r : pix_addr),
    .wdata (wdata),
    .raddr ((st_r == mfde_pkg::ST_RDB) ? raddr_r : pix_addr),
    .rdata (rdata)
  );

  // State register and clear sweep counter; reset starts a sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= mfde_pkg::ST_WIPE;
      wcnt_r <= '0;
      boot_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (st_r == mfde_pkg::ST_WIPE) wcnt_r <= wcnt_r + AW'(1);
      else                           wcnt_r <= '0;
      if ((st_r == mfde_pkg::ST_WIPE) && (wcnt_r == AW'(mfde_pkg::BUFFER_BYTES - 1))) begin
        boot_r <= 1'b0;
      end
    end
  end

  // Datapath registers: command capture and Bresenham or raster step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
      data_r   <= 8'h00;
    end else if (accept) begin
      status_r  <= stat_nxt;
      data_r    <= 8'h00;
      x_r       <= in_x_start[6:0];
      y_r       <= in_y_start[5:0];
      x0_r      <= in_x_start[6:0];
      y0_r      <= in_y_start[5:0];
      // Single pixels end after the start point, as a line with no steps.
      xe_r      <= is_line_cmd ? in_x_end : in_x_start[6:0];
      ye_r      <= is_line_cmd ? in_y_end : in_y_start[5:0];
      xmaj_r    <= is_line_cmd ? (ady < adx) : 1'b1;
      w_r       <= in_rect_width;
      h_r       <= in_rect_height;
      raddr_r   <= in_byte_address;
      dx_r      <= adx;
      dy_r      <= ady;
      sx_r      <= (in_x_end < in_x_start[6:0]);
      sy_r      <= (in_y_end < in_y_start[5:0]);
      is_line_r <= (in_mode != 3'(mfde_pkg::MODE_RECT));
      if (is_line_cmd) begin
        pop_r <= mfde_pkg::POP_SET;
        d_r   <= (ady < adx) ? ($signed({1'b0, ady, 1'b0}) - $signed({2'b0, adx}))
                             : ($signed({2'b0, ady}) - $signed({1'b0, adx, 1'b0}));
      end else begin
        pop_r <= (in_mode == 3'(mfde_pkg::MODE_RECT)) ? mfde_pkg::POP_INV
                                                      : mfde_pkg::pop_t'(in_mode[1:0]);
        d_r   <= '0;
      end
    end else if (st_r == mfde_pkg::ST_RDBW) begin
      data_r <= rdata;
    end else if (st_r == mfde_pkg::ST_NEXT) begin
      if (!is_line_r) begin
        // Raster scan down each column, then move right.
        if (y_r == y0_r + h_r[5:0] - 6'd1) begin
          y_r <= y0_r;
          x_r <= x_r + 7'd1;
        end else begin
          y_r <= y_r + 6'd1;
        end
      end else if (xmaj_r) begin
        x_r <= sx_r ? x_r - 7'd1 : x_r + 7'd1;
        if (!d_r[9]) begin
          y_r <= sy_r ? y_r - 6'd1 : y_r + 6'd1;
          d_r <= d_r - $signed({1'b0, dx_r, 1'b0}) + $signed({1'b0, dy_r, 1'b0});
        end else begin
          d_r <= d_r + $signed({1'b0, dy_r, 1'b0});
        end
      end else begin
        y_r <= sy_r ? y_r - 6'd1 : y_r + 6'd1;
        if (d_r[9] || d_r == 10'sd0) begin
          x_r <= sx_r ? x_r - 7'd1 : x_r + 7'd1;
          d_r <= d_r + $signed({1'b0, dy_r, 1'b0}) - $signed({1'b0, dx_r, 1'b0});
        end else begin
          d_r <= d_r - $signed({1'b0, dx_r, 1'b0});
        end
      end
    end
  end

endmodule
`default_nettype wire

[test/tb_mono_framebuffer_draw_engine.sv]
// Self-checking testbench for the monochrome framebuffer draw engine.
// Drives command items with random gaps and stalls and checks each result against a model.
// Depends on mfde_pkg and mono_framebuffer_draw_engine.
`timescale 1ns / 1ps
module tb_mono_framebuffer_draw_engine;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] xs;
    logic [7:0] ys;
    logic [6:0] xe;
    logic [5:0] ye;
    logic [7:0] w;
    logic [7:0] h;
    logic [9:0] addr;
  } cmd_t;

  typedef struct packed {
    logic       known;
    logic       status;
    logic [7:0] data;
  } dir_res_t;

  typedef struct packed {
    logic       status;
    logic [7:0] data;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [7:0] in_x_start = '0;
  logic [7:0] in_y_start = '0;
  logic [6:0] in_x_end = '0;
  logic [5:0] in_y_end = '0;
  logic [7:0] in_rect_width = '0;
  logic [7:0] in_rect_height = '0;
  logic [9:0] in_byte_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [7:0] out_read_data;

  logic [7:0] pixels [mfde_pkg::BUFFER_BYTES];
  res_t expected_q [$];
  dir_res_t typed_q [$];
  int errors = 0;
  int results_seen = 0;
  int sent = 0;
  bit stim_done = 1'b0;

  mono_framebuffer_draw_engine dut (.*);

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #100ms;
    $display("tb_mono_framebuffer_draw_engine: errors");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // Touch one pixel of the model; returns 1 when out of range.
  function automatic logic plot(input int x, input int y, input mfde_pkg::pop_t op);
    int a;
    logic [7:0] bm;
    if (x >= mfde_pkg::COLUMNS || y >= mfde_pkg::ROWS || x < 0 || y < 0) return 1'b1;
    a = x + (y >> 3) * mfde_pkg::COLUMNS;
    if (a >= mfde_pkg::BUFFER_BYTES) return 1'b1;
    bm = 8'(1 << (y & 7));
    case (op)
      mfde_pkg::POP_SET: pixels[a] = pixels[a] | bm;
      mfde_pkg::POP_CLR: pixels[a] = pixels[a] & ~bm;
      default:           pixels[a] = pixels[a] ^ bm;
    endcase
    return 1'b0;
  endfunction

  // Apply one command to the model and return the expected result.
  function automatic res_t draw_cmd(input cmd_t c);
    res_t r;
    int x1, y1, x2, y2, dx, dy, sx, sy, d;
    logic dummy;
    r = '0;
    x1 = c.xs; y1 = c.ys; x2 = c.xe; y2 = c.ye;
    case (mfde_pkg::mode_t'(c.mode))
      mfde_pkg::MODE_SET: r.status = plot(x1, y1, mfde_pkg::POP_SET);
      mfde_pkg::MODE_CLR: r.status = plot(x1, y1, mfde_pkg::POP_CLR);
      mfde_pkg::MODE_INV: r.status = plot(x1, y1, mfde_pkg::POP_INV);
      mfde_pkg::MODE_LINE: begin
        if (x1 >= mfde_pkg::COLUMNS || y1 >= mfde_pkg::ROWS) begin
          r.status = 1'b1;
        end else begin
          dx = x2 - x1; dy = y2 - y1; sx = 1; sy = 1;
          if (dx < 0) begin dx = -dx; sx = -1; end
          if (dy < 0) begin dy = -dy; sy = -1; end
          dummy = plot(x1, y1, mfde_pkg::POP_SET);
          if (dy < dx) begin
            d = 2 * dy - dx;
            while (x1 != x2) begin
              x1 += sx;
              if (d >= 0) begin y1 += sy; d -= 2 * dx; end
              d += 2 * dy;
              dummy = plot(x1, y1, mfde_pkg::POP_SET);
            end
          end else begin
            d = dy - 2 * dx;
            while (y1 != y2) begin
              y1 += sy;
              if (d <= 0) begin x1 += sx; d += 2 * dy; end
              d -= 2 * dx;
              dummy = plot(x1, y1, mfde_pkg::POP_SET);
            end
          end
        end
      end
      mfde_pkg::MODE_RECT: begin
        if (c.xs >= mfde_pkg::COLUMNS || c.ys >= mfde_pkg::ROWS ||
            c.xs + c.w > mfde_pkg::COLUMNS || c.ys + c.h > mfde_pkg::ROWS) begin
          r.status = 1'b1;
        end else begin
          for (int i = 0; i < c.w; i++)
            for (int j = 0; j < c.h; j++)
              dummy = plot(c.xs + i, c.ys + j, mfde_pkg::POP_INV);
        end
      end
      mfde_pkg::MODE_WIPE: begin
        foreach (pixels[k]) pixels[k] = '0;
      end
      mfde_pkg::MODE_READ: begin
        if (c.addr < mfde_pkg::BUFFER_BYTES) r.data = pixels[c.addr];
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // Random gap: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3);
    return $urandom_range(40, 10);
  endfunction

  // Send one item and record its expectation once it is accepted.
  // Valid stays high into a zero gap; the caller drops it before any wait.
  task automatic send(input cmd_t c, input dir_res_t typed);
    int g;
    in_valid <= 1'b1;
    in_mode <= c.mode; in_x_start <= c.xs; in_y_start <= c.ys;
    in_x_end <= c.xe; in_y_end <= c.ye; in_rect_width <= c.w;
    in_rect_height <= c.h; in_byte_address <= c.addr;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(draw_cmd(c));
    typed_q.push_back(typed);
    sent++;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Random command, mostly in range and small rectangles.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int p;
    c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
    p = $urandom_range(99);
    if (p < 85) begin
      c.xs = 8'($urandom_range(mfde_pkg::COLUMNS - 1));
      c.ys = 8'($urandom_range(mfde_pkg::ROWS - 1));
      c.addr = 10'($urandom_range(mfde_pkg::BUFFER_BYTES - 1));
      c.w = 8'($urandom_range(12));
      c.h = 8'($urandom_range(12));
      if (c.xs + c.w > mfde_pkg::COLUMNS) c.w = 8'(mfde_pkg::COLUMNS - c.xs);
      if (c.ys + c.h > mfde_pkg::ROWS) c.h = 8'(mfde_pkg::ROWS - c.ys);
    end
    p = $urandom_range(99);
    if (p < 2) c.mode = mfde_pkg::MODE_WIPE;
    else if (p < 4) c.mode = mfde_pkg::MODE_BAD;
    else if (p < 30) c.mode = mfde_pkg::MODE_READ;
    else if (p < 45) c.mode = mfde_pkg::MODE_LINE;
    else if (p < 55) c.mode = mfde_pkg::MODE_RECT;
    else c.mode = 3'($urandom_range(2));
    return c;
  endfunction

  function automatic cmd_t mk(input mfde_pkg::mode_t m, input int xs, input int ys,
                              input int xe, input int ye, input int w, input int h,
                              input int a);
    cmd_t c;
    c.mode = m; c.xs = 8'(xs); c.ys = 8'(ys); c.xe = 7'(xe); c.ye = 6'(ye);
    c.w = 8'(w); c.h = 8'(h); c.addr = 10'(a);
    return c;
  endfunction

  // Stimulus: directed table, then random items.
  initial begin
    cmd_t dir_cmd [$];
    dir_res_t dir_exp [$];
    dir_res_t none;
    none = '0;
    foreach (pixels[k]) pixels[k] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    dir_cmd = '{
      mk(mfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 1023),
      mk(mfde_pkg::MODE_SET, 0, 0, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_SET, 127, 63, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 1023),
      mk(mfde_pkg::MODE_SET, 128, 0, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_CLR, 0, 64, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_INV, 255, 255, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_CLR, 0, 0, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_INV, 5, 9, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_LINE, 0, 0, 127, 63, 0, 0, 0),
      mk(mfde_pkg::MODE_LINE, 127, 0, 0, 10, 0, 0, 0),
      mk(mfde_pkg::MODE_LINE, 20, 40, 30, 10, 0, 0, 0),
      mk(mfde_pkg::MODE_LINE, 10, 10, 20, 20, 0, 0, 0),
      mk(mfde_pkg::MODE_LINE, 50, 5, 50, 5, 0, 0, 0),
      mk(mfde_pkg::MODE_LINE, 200, 0, 10, 10, 0, 0, 0),
      mk(mfde_pkg::MODE_RECT, 0, 0, 0, 0, 128, 1, 0),
      mk(mfde_pkg::MODE_RECT, 120, 56, 0, 0, 8, 8, 0),
      mk(mfde_pkg::MODE_RECT, 10, 10, 0, 0, 0, 5, 0),
      mk(mfde_pkg::MODE_RECT, 120, 0, 0, 0, 9, 1, 0),
      mk(mfde_pkg::MODE_RECT, 0, 60, 0, 0, 1, 255, 0),
      mk(mfde_pkg::MODE_BAD, 0, 0, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 200),
      mk(mfde_pkg::MODE_WIPE, 0, 0, 0, 0, 0, 0, 0),
      mk(mfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0)
    };
    dir_exp = '{
      '{1'b1, 1'b0, 8'h00}, '{1'b1, 1'b0, 8'h00}, '{1'b1, 1'b0, 8'h00},
      '{1'b1, 1'b0, 8'h01}, '{1'b1, 1'b0, 8'h00}, '{1'b1, 1'b0, 8'h80},
      '{1'b1, 1'b1, 8'h00}, '{1'b1, 1'b1, 8'h00}, '{1'b1, 1'b1, 8'h00},
      none, none, none, none, none, none, none,
      '{1'b1, 1'b1, 8'h00}, none, none, '{1'b1, 1'b0, 8'h00},
      '{1'b1, 1'b1, 8'h00}, '{1'b1, 1'b1, 8'h00}, '{1'b1, 1'b1, 8'h00},
      none, '{1'b1, 1'b0, 8'h00}, '{1'b1, 1'b0, 8'h00}
    };
    foreach (dir_cmd[i]) send(dir_cmd[i], dir_exp[i]);
    for (int n = 0; n < 1950; n++) begin
      // One hold-off until the engine has drained.
      if (n == 900) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_q.size() != 0);
      end
      send(rand_cmd(), none);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls, then field checks at the rising edge.
  initial begin
    res_t want;
    dir_res_t typed;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = expected_q.pop_front();
          typed = typed_q.pop_front();
          results_seen++;
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_read_data !== want.data) report("read_data", out_read_data, want.data);
          if (typed.known && (typed.status !== want.status || typed.data !== want.data))
            report("table row", {want.status, want.data}, {typed.status, typed.data});
        end
      end
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        hold = gap_len();
        if ($urandom_range(3) == 0) hold = 0;
      end
      out_stall <= (hold > 0);
    end
  end

  // End of run: drain, settle, then report.
  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (expected_q.size() != 0) report("leftover expectations", expected_q.size(), 0);
    $display("Covered %0d commands (pixel, line, rectangle, clear, read, invalid mode),",
             sent);
    $display("with %0d results checked under random gaps and stalls.", results_seen);
    if (errors == 0)
      $display("tb_mono_framebuffer_draw_engine: clean");
    else
      $display("tb_mono_framebuffer_draw_engine: errors");
    $finish;
  end
endmodule

[files.f]
src/mfde_pkg.sv
src/mfde_fb_ram.sv
src/mono_framebuffer_draw_engine.sv
test/tb_mono_framebuffer_draw_engine.sv
